// File: design/ordered_list_store_top_defines.svh
// Assertion macros for the ordered list store.
// Used by ordered_list_store_top; expects clk and rst_n in scope.
`ifndef ORDERED_LIST_STORE_TOP_DEFINES_SVH
`define ORDERED_LIST_STORE_TOP_DEFINES_SVH

// same-cycle implication
`define OLST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OLST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/olst_pkg.sv
// Shared types and codes for the ordered list store.
// No dependencies.
`timescale 1ns / 1ps

package olst_pkg;

    localparam logic [2:0] OP_INSERT_AT     = 3'd0;
    localparam logic [2:0] OP_INSERT_SORTED = 3'd1;
    localparam logic [2:0] OP_ERASE_AT      = 3'd2;
    localparam logic [2:0] OP_REMOVE_ALL    = 3'd3;
    localparam logic [2:0] OP_GET           = 3'd4;
    localparam logic [2:0] OP_SET           = 3'd5;
    localparam logic [2:0] OP_FIND          = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADPOS   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  pos;
        logic [31:0] value;
    } olst_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  index;
        logic [31:0] read_value;
        logic [5:0]  removed_count;
        logic [5:0]  item_count;
    } olst_rsp_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_LEFT,
        CELL_TAKE_RIGHT,
        CELL_LOAD
    } cell_sel_t;

    typedef struct packed {
        cell_sel_t sel;
        logic      flag_load;
    } cell_ctrl_t;

endpackage

// File: design/olst_stream_if.sv
// Valid/ready item channel with a typed payload.
// Payload types come from olst_pkg at instantiation.
`timescale 1ns / 1ps

interface olst_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: design/ordered_list_store_top.sv
// Ordered list store: an accepted item passes the compare state (ST_EVAL), then the
// shift state (ST_EXEC), which writes the result register once the output is free;
// remove_all uses ST_REMOVE instead, one shift per match. A new item is taken in the
// state that writes the result. Reset clears occupancy and control, not entries.
// Depends on olst_pkg, olst_stream_if, olst_cell and ordered_list_store_top_defines.svh.
`timescale 1ns / 1ps
`include "ordered_list_store_top_defines.svh"

module ordered_list_store_top #(
    parameter int CAPACITY = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    olst_stream_if.sink   req,
    olst_stream_if.source rsp
);

    localparam int OW = $clog2(CAPACITY + 1);
    localparam int CW = (OW > 6) ? OW : 6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EXEC,
        ST_REMOVE
    } state_t;

    state_t              state_reg, state_next;
    logic [2:0]          op_reg, op_next;
    logic [5:0]          pos_reg, pos_next;
    logic [31:0]         value_reg, value_next;
    logic [OW-1:0]       occ_reg, occ_next;
    logic [OW-1:0]       removed_reg, removed_next;
    logic                rsp_valid_reg, rsp_valid_next;
    olst_pkg::olst_rsp_t rsp_payload_reg, rsp_payload_next;

    olst_pkg::cell_ctrl_t ctrl [CAPACITY];
    logic [31:0]          cell_entry [CAPACITY];
    logic [CAPACITY-1:0]  cell_eq;
    logic [CAPACITY-1:0]  cell_lt;

    logic [CW-1:0]       occ_w;
    logic [CW-1:0]       pos_w;
    logic [CAPACITY-1:0] valid_v, eq_v, ge_v;
    logic [CAPACITY-1:0] ins_g, ins_neg, ins_first, ins_region;
    logic [CAPACITY-1:0] rm_neg, rm_first, rm_region;
    logic [CAPACITY-1:0] pos_first, pos_region;
    logic [31:0]         rd_sel;
    logic [4:0]          ins_idx, find_idx;
    logic                full, slot_free, accept, ready;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            olst_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl[g]),
                .value       (value_reg),
                .left_entry  ((g == 0) ? value_reg : cell_entry[(g == 0) ? 0 : g - 1]),
                .right_entry ((g == CAPACITY - 1) ? value_reg
                                  : cell_entry[(g == CAPACITY - 1) ? g : g + 1]),
                .right_eq    ((g == CAPACITY - 1) ? 1'b0
                                  : cell_eq[(g == CAPACITY - 1) ? g : g + 1]),
                .entry       (cell_entry[g]),
                .eq          (cell_eq[g]),
                .lt          (cell_lt[g])
            );
        end
    endgenerate

    assign occ_w     = CW'(occ_reg);
    assign pos_w     = CW'(pos_reg);
    assign full      = (occ_w == CW'(CAPACITY));
    assign slot_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            valid_v[k]    = (CW'(k) < occ_w);
            pos_first[k]  = (CW'(k) == pos_w);
            pos_region[k] = (CW'(k) >= pos_w);
        end
    end

    assign eq_v       = cell_eq & valid_v;
    assign ge_v       = valid_v & ~cell_lt;
    assign ins_g      = ge_v | ~valid_v;
    assign ins_neg    = ~ins_g + CAPACITY'(1);
    assign ins_first  = ins_g & ins_neg;
    assign ins_region = ins_g | ins_neg;
    assign rm_neg     = ~eq_v + CAPACITY'(1);
    assign rm_first   = eq_v & rm_neg;
    assign rm_region  = eq_v | rm_neg;

    always_comb
    begin
        rd_sel   = '0;
        ins_idx  = '0;
        find_idx = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            rd_sel   = rd_sel | (cell_entry[k] & {32{pos_first[k]}});
            ins_idx  = ins_idx | (5'(k) & {5{ins_first[k]}});
            find_idx = find_idx | (5'(k) & {5{rm_first[k]}});
        end
    end

    assign ready = (state_reg == ST_IDLE)
                || ((state_reg == ST_EXEC) && slot_free)
                || ((state_reg == ST_REMOVE) && !(|eq_v) && slot_free);
    assign accept = req.valid && ready;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        pos_next         = pos_reg;
        value_next       = value_reg;
        occ_next         = occ_reg;
        removed_next     = removed_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_payload_next = rsp_payload_reg;
        for (int k = 0; k < CAPACITY; k++)
        begin
            ctrl[k].sel       = olst_pkg::CELL_HOLD;
            ctrl[k].flag_load = (state_reg == ST_EVAL);
        end

        case (state_reg)
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_EVAL:
            begin
                removed_next = '0;
                state_next   = (op_reg == olst_pkg::OP_REMOVE_ALL) ? ST_REMOVE : ST_EXEC;
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    rsp_payload_next               = '0;
                    rsp_payload_next.status        = olst_pkg::ST_OK;
                    case (op_reg)
                        olst_pkg::OP_INSERT_AT:
                        begin
                            if (pos_w > occ_w)
                                rsp_payload_next.status = olst_pkg::ST_BADPOS;
                            else if (full)
                                rsp_payload_next.status = olst_pkg::ST_FULL;
                            else
                            begin
                                for (int k = 0; k < CAPACITY; k++)
                                begin
                                    if (pos_first[k])
                                        ctrl[k].sel = olst_pkg::CELL_LOAD;
                                    else if (pos_region[k])
                                        ctrl[k].sel = olst_pkg::CELL_TAKE_LEFT;
                                end
                                occ_next = occ_reg + 1'b1;
                                rsp_payload_next.index = pos_reg[4:0];
                            end
                        end
                        olst_pkg::OP_INSERT_SORTED:
                        begin
                            if (full)
                                rsp_payload_next.status = olst_pkg::ST_FULL;
                            else
                            begin
                                for (int k = 0; k < CAPACITY; k++)
                                begin
                                    if (ins_first[k])
                                        ctrl[k].sel = olst_pkg::CELL_LOAD;
                                    else if (ins_region[k])
                                        ctrl[k].sel = olst_pkg::CELL_TAKE_LEFT;
                                end
                                occ_next = occ_reg + 1'b1;
                                rsp_payload_next.index = ins_idx;
                            end
                        end
                        olst_pkg::OP_ERASE_AT:
                        begin
                            if (pos_w >= occ_w)
                                rsp_payload_next.status = olst_pkg::ST_BADPOS;
                            else
                            begin
                                for (int k = 0; k < CAPACITY; k++)
                                begin
                                    if (pos_region[k])
                                        ctrl[k].sel = olst_pkg::CELL_TAKE_RIGHT;
                                end
                                occ_next = occ_reg - 1'b1;
                            end
                        end
                        olst_pkg::OP_GET:
                        begin
                            if (pos_w >= occ_w)
                                rsp_payload_next.status = olst_pkg::ST_BADPOS;
                            else
                                rsp_payload_next.read_value = rd_sel;
                        end
                        olst_pkg::OP_SET:
                        begin
                            if (pos_w >= occ_w)
                                rsp_payload_next.status = olst_pkg::ST_BADPOS;
                            else
                            begin
                                for (int k = 0; k < CAPACITY; k++)
                                begin
                                    if (pos_first[k])
                                        ctrl[k].sel = olst_pkg::CELL_LOAD;
                                end
                            end
                        end
                        olst_pkg::OP_FIND:
                        begin
                            if (|eq_v)
                                rsp_payload_next.index = find_idx;
                            else
                                rsp_payload_next.status = olst_pkg::ST_NOTFOUND;
                        end
                        default:
                        begin
                            rsp_payload_next.status = olst_pkg::ST_OK;
                        end
                    endcase
                    rsp_payload_next.item_count = 6'(occ_next);
                    rsp_valid_next              = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end
            ST_REMOVE:
            begin
                if (|eq_v)
                begin
                    // drop the lowest match; its flag row shifts down with the data
                    for (int k = 0; k < CAPACITY; k++)
                    begin
                        if (rm_region[k])
                            ctrl[k].sel = olst_pkg::CELL_TAKE_RIGHT;
                    end
                    occ_next     = occ_reg - 1'b1;
                    removed_next = removed_reg + 1'b1;
                end
                else if (slot_free)
                begin
                    rsp_payload_next               = '0;
                    rsp_payload_next.status        = olst_pkg::ST_OK;
                    rsp_payload_next.removed_count = 6'(removed_reg);
                    rsp_payload_next.item_count    = 6'(occ_reg);
                    rsp_valid_next                 = 1'b1;
                    state_next                     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (accept)
        begin
            op_next    = req.payload.op;
            pos_next   = req.payload.pos;
            value_next = req.payload.value;
            state_next = ST_EVAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            removed_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            removed_reg   <= removed_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        pos_reg         <= pos_next;
        value_reg       <= value_next;
        rsp_payload_reg <= rsp_payload_next;
    end

    assign req.ready   = ready;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_payload_reg;

    `OLST_ASSERT_NOW(a_occ_bound, 1'b1, occ_w <= CW'(CAPACITY), "occupancy above capacity")
    `OLST_ASSERT_NEXT(a_remove_step, (state_reg == ST_REMOVE) && (|eq_v),
        occ_reg == OW'($past(occ_reg) - 1'b1), "remove step did not shrink the list")
    `OLST_ASSERT_NEXT(a_accept_eval, req.valid && req.ready, state_reg == ST_EVAL,
        "accepted item did not enter compare cycle")
    `OLST_ASSERT_NOW(a_sorted_onehot,
        (state_reg == ST_EXEC) && (op_reg == olst_pkg::OP_INSERT_SORTED) && !full,
        $onehot(ins_first), "sorted insert slot not unique")

endmodule

// File: design/olst_cell.sv
// One list slot: holds an entry and its compare flags, shifts with neighbors.
// Depends on olst_pkg.
`timescale 1ns / 1ps

module olst_cell (
    input  logic                clk,
    input  olst_pkg::cell_ctrl_t ctrl,
    input  logic [31:0]         value,
    input  logic [31:0]         left_entry,
    input  logic [31:0]         right_entry,
    input  logic                right_eq,
    output logic [31:0]         entry,
    output logic                eq,
    output logic                lt
);

    logic [31:0] entry_reg;
    logic [31:0] entry_next;
    logic        eq_reg;
    logic        eq_next;
    logic        lt_reg;
    logic        lt_next;

    always_comb
    begin
        entry_next = entry_reg;
        eq_next    = eq_reg;
        lt_next    = lt_reg;
        case (ctrl.sel)
            olst_pkg::CELL_HOLD:       entry_next = entry_reg;
            olst_pkg::CELL_TAKE_LEFT:  entry_next = left_entry;
            olst_pkg::CELL_TAKE_RIGHT:
            begin
                entry_next = right_entry;
                eq_next    = right_eq;
            end
            olst_pkg::CELL_LOAD:       entry_next = value;
            default:                   entry_next = entry_reg;
        endcase
        if (ctrl.flag_load)
        begin
            eq_next = (entry_reg == value);
            lt_next = (entry_reg < value);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        eq_reg    <= eq_next;
        lt_reg    <= lt_next;
    end

    assign entry = entry_reg;
    assign eq    = eq_reg;
    assign lt    = lt_reg;

endmodule
